@@ src/rgb_box_filter_3x3_top_assert.svh @@
// assertion macros for the box filter, empty when synthesizing
`ifndef RGB_BOX_FILTER_3X3_TOP_ASSERT_SVH
`define RGB_BOX_FILTER_3X3_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define RBF3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true at a clock edge out of reset
`define RBF3_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`else

`define RBF3_ASSERT(lbl, prop, msg)
`define RBF3_ASSERT_NEVER(lbl, prop, msg)

`endif

`endif

@@ src/rbf3_pkg.sv @@
`default_nettype none

package rbf3_pkg;

  localparam int MaxWidthDef  = 1024;
  localparam int MaxHeightDef = 4096;
  localparam int FifoDepthDef = 8;

  localparam int WidthRegW  = 11;
  localparam int HeightRegW = 13;
  localparam int CfgDataW   = 13;
  localparam int CfgIdxW    = 1;

  localparam logic [CfgIdxW-1:0] CfgIdxWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxHeight = 1'b1;

  localparam int ResetWidth  = 1024;
  localparam int ResetHeight = 1024;

  // ceil(2^16 / 9), exact for sums up to 2295
  localparam logic [12:0] Recip9 = 13'd7282;

  typedef struct packed {
    logic       mode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       run_last;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // one window column, top row first
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } col_t;

  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } line_pair_t;

  typedef struct packed {
    logic [9:0] red;
    logic [9:0] green;
    logic [9:0] blue;
  } chan_sum_t;

  typedef struct packed {
    logic [11:0] red;
    logic [11:0] green;
    logic [11:0] blue;
  } win_sum_t;

  // results of one item: res0 is always used, res1 only when two is set
  typedef struct packed {
    logic      two;
    out_item_t res0;
    out_item_t res1;
  } out_pair_t;

  typedef struct packed {
    logic wr;
    logic clr;
    logic top_en;
    logic mid_en;
    logic emit_full;
    logic emit_edge;
    logic frame_last;
  } stage_ctl_t;

  function automatic logic [7:0] div9(input logic [11:0] s);
    logic [24:0] p;
    p = 25'(s) * 25'(Recip9);
    return p[23:16];
  endfunction

endpackage

`default_nettype wire

@@ src/rbf3_line_buf.sv @@
`default_nettype none

module rbf3_line_buf #(
  parameter int Depth = 1024,
  parameter int AddrW = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rd_en_i,
  input  wire logic [AddrW-1:0]       rd_addr_i,
  output rbf3_pkg::line_pair_t        rd_data_o,
  input  wire logic                   wr_en_i,
  input  wire logic [AddrW-1:0]       wr_addr_i,
  input  wire rbf3_pkg::line_pair_t   wr_data_i
);
  import rbf3_pkg::*;

  line_pair_t mem [Depth];
  line_pair_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      // same column written this cycle: hand the new data straight over
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ src/rbf3_col_cell.sv @@
`default_nettype none

module rbf3_col_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          restart_i,
  input  wire logic          shift_i,
  input  wire logic          clr_i,
  input  wire rbf3_pkg::col_t col_i,
  output rbf3_pkg::col_t     col_o,
  output rbf3_pkg::chan_sum_t sum_o
);
  import rbf3_pkg::*;

  col_t col_q;
  col_t col_d;

  always_comb begin
    col_d = col_q;
    if (restart_i) begin
      col_d = '0;
    end else if (shift_i) begin
      col_d = clr_i ? '0 : col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

  assign sum_o.red   = 10'(col_q.top.red)   + 10'(col_q.mid.red)   + 10'(col_q.bot.red);
  assign sum_o.green = 10'(col_q.top.green) + 10'(col_q.mid.green) + 10'(col_q.bot.green);
  assign sum_o.blue  = 10'(col_q.top.blue)  + 10'(col_q.mid.blue)  + 10'(col_q.bot.blue);

endmodule

`default_nettype wire

@@ src/rbf3_out_fifo.sv @@
`default_nettype none

module rbf3_out_fifo #(
  parameter int Depth = 8,
  parameter int CntW  = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rbf3_pkg::out_pair_t push_data_i,
  output logic [CntW-1:0]      count_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output rbf3_pkg::out_item_t  out_data_o
);
  import rbf3_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  out_pair_t         mem [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              sub_q, sub_d;
  out_pair_t         head;
  logic              take;
  logic              pop;

  assign head        = mem[rd_ptr_q];
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = sub_q ? head.res1 : head.res0;
  assign take        = out_valid_o && !out_stall_i;
  // an entry leaves after its last item is taken
  assign pop         = take && (!head.two || sub_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    sub_d    = sub_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (take) begin
      sub_d = !pop;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      sub_q    <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      sub_q    <= sub_d;
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

@@ src/rgb_box_filter_3x3_top.sv @@
// 3x3 box filter over an rgb raster stream, one column cell per window column.
// a result passes the line store read, window and window sum registers before it is queued.
// throughput: one item per cycle; a row end gives two results, so the output port
// paces the stream then, and input is held off once queued and in-flight items reach FIFO_DEPTH (8 by default).
// reset (async, active low) clears counters, window, queue and sets width and height
// to 1024; the line stores are not cleared, rows above the frame are masked instead.
`default_nettype none

`include "rgb_box_filter_3x3_top_assert.svh"

module rgb_box_filter_3x3_top #(
  parameter int MAX_WIDTH  = rbf3_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = rbf3_pkg::MaxHeightDef,
  parameter int FIFO_DEPTH = rbf3_pkg::FifoDepthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rbf3_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [rbf3_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire rbf3_pkg::in_item_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output rbf3_pkg::out_item_t                  out_data_o
);
  import rbf3_pkg::*;

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW   = $clog2(MAX_HEIGHT + 1);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);
  localparam int RstWidthEff  = (ResetWidth > MAX_WIDTH) ? MAX_WIDTH : ResetWidth;
  localparam int RstHeightEff = (ResetHeight > MAX_HEIGHT) ? MAX_HEIGHT : ResetHeight;

  // configuration, held as effective values
  logic [CW-1:0] width_last_q, width_last_d;
  logic [RW-1:0] height_q, height_d;
  logic          restart;
  logic [31:0]   wv, hv;

  // position of the next item
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic       accept;
  logic       live;
  logic       flush_due;
  logic       go;
  stage_ctl_t ctl0;

  // stage 1: line store read data arrives
  logic          v1_q;
  stage_ctl_t    ctl1_q;
  pixel_t        pix1_q;
  logic [CW-1:0] addr1_q;
  line_pair_t    rd_data;
  line_pair_t    wr_data;
  col_t          new_col;

  // stage 2: window holds the item's neighborhood
  logic       v2_q;
  stage_ctl_t ctl2_q;
  col_t       win_col [3];
  chan_sum_t  col_sum [3];

  // stage 3: window sums
  logic       v3_q;
  stage_ctl_t ctl3_q;
  win_sum_t   sum9_q, sum6_q;

  out_item_t       res_full, res_edge;
  out_pair_t       pair;
  logic            push;
  logic [CntW-1:0] fifo_cnt;
  logic [CntW:0]   pending;

  // ---------------- configuration ----------------
  assign restart = cfg_we_i && ((cfg_index_i == CfgIdxWidth) || (cfg_index_i == CfgIdxHeight));

  always_comb begin
    wv = 32'(cfg_data_i[WidthRegW-1:0]);
    hv = 32'(cfg_data_i[HeightRegW-1:0]);
    if (wv == 32'd0) begin
      wv = 32'd1;
    end else if (wv > 32'(MAX_WIDTH)) begin
      wv = 32'(MAX_WIDTH);
    end
    if (hv == 32'd0) begin
      hv = 32'd1;
    end else if (hv > 32'(MAX_HEIGHT)) begin
      hv = 32'(MAX_HEIGHT);
    end
    width_last_d = width_last_q;
    height_d     = height_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgIdxWidth:  width_last_d = CW'(wv - 32'd1);
        CfgIdxHeight: height_d     = RW'(hv);
        default:      ;
      endcase
    end
  end

  // ---------------- stage 0: accept and position ----------------
  assign pending    = (CntW+1)'(fifo_cnt) + (CntW+1)'(v1_q) + (CntW+1)'(v2_q)
                    + (CntW+1)'(v3_q);
  assign in_stall_o = (pending > (CntW+1)'(FIFO_DEPTH - 1));
  assign accept     = in_valid_i && !in_stall_o;
  assign flush_due  = (row_q == height_q);
  // pixels during the flush row and flush steps during the frame are dropped
  assign live       = (in_data_i.mode == flush_due);
  assign go         = accept && live;

  always_comb begin
    ctl0.wr         = !flush_due;
    ctl0.clr        = (col_q == '0);
    ctl0.top_en     = (row_q > RW'(1));
    ctl0.mid_en     = (row_q != '0);
    ctl0.emit_full  = (row_q != '0) && (col_q != '0);
    ctl0.emit_edge  = (row_q != '0) && (col_q == width_last_q);
    ctl0.frame_last = flush_due;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (go) begin
      if (col_q == width_last_q) begin
        col_d = '0;
        row_d = flush_due ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_last_q <= CW'(RstWidthEff - 1);
      height_q     <= RW'(RstHeightEff);
      col_q        <= '0;
      row_q        <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
    end else begin
      width_last_q <= width_last_d;
      height_q     <= height_d;
      col_q        <= col_d;
      row_q        <= row_d;
      v1_q         <= go;
      v2_q         <= v1_q;
      v3_q         <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      ctl1_q  <= ctl0;
      addr1_q <= col_q;
      pix1_q  <= in_data_i.mode ? '0 :
                 pixel_t'{red: in_data_i.red_in, green: in_data_i.green_in,
                          blue: in_data_i.blue_in};
    end
  end

  rbf3_line_buf #(
    .Depth (MAX_WIDTH),
    .AddrW (CW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (go),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (v1_q && ctl1_q.wr),
    .wr_addr_i (addr1_q),
    .wr_data_i (wr_data)
  );

  // ---------------- stage 1: window shift ----------------
  // the newer row moves down to the older store, the pixel becomes the newer row
  assign wr_data.older = rd_data.newer;
  assign wr_data.newer = pix1_q;

  assign new_col.top = ctl1_q.top_en ? rd_data.older : '0;
  assign new_col.mid = ctl1_q.mid_en ? rd_data.newer : '0;
  assign new_col.bot = pix1_q;

  for (genvar i = 0; i < 3; i++) begin : g_cell
    if (i == 2) begin : g_right
      rbf3_col_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .restart_i (restart),
        .shift_i   (v1_q),
        .clr_i     (1'b0),
        .col_i     (new_col),
        .col_o     (win_col[i]),
        .sum_o     (col_sum[i])
      );
    end else begin : g_inner
      // row start: the left two columns fall outside the frame
      rbf3_col_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .restart_i (restart),
        .shift_i   (v1_q),
        .clr_i     (ctl1_q.clr),
        .col_i     (win_col[i+1]),
        .col_o     (win_col[i]),
        .sum_o     (col_sum[i])
      );
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      ctl2_q <= ctl1_q;
    end
  end

  // ---------------- stage 2: window sums ----------------
  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      ctl3_q       <= ctl2_q;
      sum6_q.red   <= 12'(col_sum[1].red)   + 12'(col_sum[2].red);
      sum6_q.green <= 12'(col_sum[1].green) + 12'(col_sum[2].green);
      sum6_q.blue  <= 12'(col_sum[1].blue)  + 12'(col_sum[2].blue);
      sum9_q.red   <= 12'(col_sum[0].red)   + 12'(col_sum[1].red)   + 12'(col_sum[2].red);
      sum9_q.green <= 12'(col_sum[0].green) + 12'(col_sum[1].green) + 12'(col_sum[2].green);
      sum9_q.blue  <= 12'(col_sum[0].blue)  + 12'(col_sum[1].blue)  + 12'(col_sum[2].blue);
    end
  end

  // ---------------- stage 3: divide by nine, queue ----------------
  always_comb begin
    res_full.red_out    = div9(sum9_q.red);
    res_full.green_out  = div9(sum9_q.green);
    res_full.blue_out   = div9(sum9_q.blue);
    res_full.run_last   = !ctl3_q.emit_edge;
    res_full.frame_last = 1'b0;
    res_edge.red_out    = div9(sum6_q.red);
    res_edge.green_out  = div9(sum6_q.green);
    res_edge.blue_out   = div9(sum6_q.blue);
    res_edge.run_last   = 1'b1;
    res_edge.frame_last = ctl3_q.frame_last;
    pair.two  = ctl3_q.emit_full && ctl3_q.emit_edge;
    pair.res0 = ctl3_q.emit_full ? res_full : res_edge;
    pair.res1 = res_edge;
  end

  assign push = v3_q && (ctl3_q.emit_full || ctl3_q.emit_edge);

  rbf3_out_fifo #(
    .Depth (FIFO_DEPTH),
    .CntW  (CntW)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (pair),
    .count_o     (fifo_cnt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // ---------------- checks ----------------
  `RBF3_ASSERT(a_credit_bound, pending <= (CntW+1)'(FIFO_DEPTH), "results in flight exceed queue depth")
  `RBF3_ASSERT(a_col_in_row, col_q <= width_last_q, "column counter beyond row end")
  `RBF3_ASSERT(a_row_in_frame, row_q <= height_q, "row counter beyond flush row")
  `RBF3_ASSERT_NEVER(a_frame_last_alone, out_valid_o && out_data_o.frame_last && !out_data_o.run_last, "frame end not on last item of its run")

endmodule

`default_nettype wire
